// ----- rtl/core/jets_pkg.sv -----
`default_nettype none
package jets_pkg;
  localparam int MaxIterDef = 150;
  localparam int FracBitsDef = 28;
  localparam int HueSpan = 360;
  localparam int SectorW = 43;
  localparam int HsvSat = 150;
  localparam int HsvVal = 150;
  localparam int CfgAddrW = 4;
  localparam logic [31:0] CReRst = 32'sd76502958;
  localparam logic [31:0] CImRst = 32'sd2684355;
  localparam logic [31:0] RowStepRst = 32'sd894785;
  localparam logic [31:0] ColStepRst = 32'sd671089;

  typedef enum logic [1:0] {
    REG_C_REAL = 2'd0,
    REG_C_IMAG = 2'd1,
    REG_ROW_STEP = 2'd2,
    REG_COL_STEP = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_COLOR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    logic signed [31:0] r;
    if (v > 96'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -96'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [7:0] mul_hi8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] m;
    m = 16'(a) * 16'(b);
    return m[15:8];
  endfunction

  function automatic logic [23:0] hsv_rgb(input logic [7:0] h);
    logic [7:0] sec, f, rem, p, q, t, v, s, r, g, b;
    logic [15:0] mm;
    v = 8'(HsvVal);
    s = 8'(HsvSat);
    if (h >= 8'(5 * SectorW)) sec = 8'd5;
    else if (h >= 8'(4 * SectorW)) sec = 8'd4;
    else if (h >= 8'(3 * SectorW)) sec = 8'd3;
    else if (h >= 8'(2 * SectorW)) sec = 8'd2;
    else if (h >= 8'(SectorW)) sec = 8'd1;
    else sec = 8'd0;
    rem = 8'(h - 8'(16'(sec) * 16'(SectorW)));
    mm = 16'(rem) * 16'd6;
    f = mm[7:0];
    p = mul_hi8(v, 8'd255 - s);
    q = mul_hi8(v, 8'd255 - mul_hi8(s, f));
    t = mul_hi8(v, 8'd255 - mul_hi8(s, 8'd255 - f));
    case (sec)
      8'd0: begin r = v; g = t; b = p; end
      8'd1: begin r = q; g = v; b = p; end
      8'd2: begin r = p; g = v; b = t; end
      8'd3: begin r = p; g = q; b = v; end
      8'd4: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    return {r, g, b};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/jets_cell.sv -----
`default_nettype none
module jets_cell #(
  parameter int FRAC_BITS = jets_pkg::FracBitsDef
) (
  input  wire logic clk,
  input  wire logic load,
  input  wire logic step,
  input  wire logic signed [31:0] z_init,
  input  wire logic signed [31:0] c_val,
  input  wire logic signed [31:0] nb_z,
  input  wire logic signed [63:0] prod_in,
  output logic signed [31:0] z_out,
  output logic signed [63:0] sq_out
);
  import jets_pkg::*;
  logic signed [31:0] z_r;
  logic signed [95:0] nxt;
  // Each cell holds one part of z and takes a registered product term.
  assign nxt = 96'(prod_in >>> FRAC_BITS) + 96'(c_val);
  always_ff @(posedge clk) begin
    if (load) z_r <= z_init;
    else if (step) z_r <= sat32(nxt);
  end
  assign z_out = z_r;
  assign sq_out = 64'(z_r) * 64'(nb_z);
endmodule
`default_nettype wire

// ----- rtl/core/julia_escape_time_pixel.sv -----
// Each pixel runs N iterations (0..MAX_ITER) before its result is loaded for output.
// One pixel at a time: a new input is accepted only once the last result is loaded.
// In each iteration the squares are registered, then z is checked and updated.
// The result register frees the input as soon as a result is waiting.
// Reset is synchronous, active low; only control and config registers take listed values.
`default_nettype none
module julia_escape_time_pixel #(
  parameter int MAX_ITER = jets_pkg::MaxIterDef,
  parameter int FRAC_BITS = jets_pkg::FracBitsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [9:0] in_row,
  input  wire logic [9:0] in_col,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_iter_count,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [jets_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import jets_pkg::*;
  localparam int IW = $clog2(MAX_ITER + 1);
  localparam int HueQ = HueSpan / MAX_ITER;
  localparam int HueRem = HueSpan % MAX_ITER;

  logic signed [31:0] c_re_r, c_im_r, rstep_r, cstep_r;
  state_t st_r, st_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic phase_r, phase_nxt;
  logic [7:0] hq_r, hq_nxt;
  logic [IW-1:0] hr_r, hr_nxt;
  logic [IW:0] hsum;
  logic [7:0] hue_r;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] red_r, green_r, blue_r, itc_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  logic signed [31:0] zr, zi, zr0, zi0;
  logic signed [63:0] ri_a, ir_b;
  logic load, upd;
  reg_idx_t widx;

  assign pready = 1'b1;
  assign widx = reg_idx_t'(paddr[3:2]);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_re_r <= CReRst; c_im_r <= CImRst;
      rstep_r <= RowStepRst; cstep_r <= ColStepRst;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_C_REAL: c_re_r <= pwdata;
        REG_C_IMAG: c_im_r <= pwdata;
        REG_ROW_STEP: rstep_r <= pwdata;
        REG_COL_STEP: cstep_r <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (widx)
      REG_C_REAL: prdata = c_re_r;
      REG_C_IMAG: prdata = c_im_r;
      REG_ROW_STEP: prdata = rstep_r;
      default: prdata = cstep_r;
    endcase
  end

  assign zr0 = sat32(96'($signed({1'b0, in_col})) * 96'(cstep_r) - (96'sd1 <<< FRAC_BITS));
  assign zi0 = sat32(96'($signed({1'b0, in_row})) * 96'(rstep_r) - (96'sd1 <<< FRAC_BITS));

  jets_cell #(.FRAC_BITS(FRAC_BITS)) u_re (
    .clk(clk), .load(load), .step(upd), .z_init(zr0), .c_val(c_re_r),
    .nb_z(zi), .prod_in(rr_r - ii_r), .z_out(zr), .sq_out(ri_a));
  jets_cell #(.FRAC_BITS(FRAC_BITS - 1)) u_im (
    .clk(clk), .load(load), .step(upd), .z_init(zi0), .c_val(c_im_r),
    .nb_z(zr), .prod_in(ri_r), .z_out(zi), .sq_out(ir_b));

  logic [64:0] norm;
  logic esc_now;
  assign norm = 65'(rr_r) + 65'(ii_r);
  assign esc_now = (norm >> FRAC_BITS) >= (65'd4 << FRAC_BITS);
  logic unused;
  assign unused = ^{ir_b, paddr[1:0]};

  always_ff @(posedge clk) begin
    rr_r <= 64'(zr) * 64'(zr);
    ii_r <= 64'(zi) * 64'(zi);
    ri_r <= ri_a;
  end

  assign in_stall = (st_r != ST_IDLE);

  assign hsum = {1'b0, hr_r} + (IW+1)'(HueRem);

  always_comb begin
    st_nxt = st_r; it_nxt = it_r; phase_nxt = phase_r;
    hq_nxt = hq_r; hr_nxt = hr_r;
    load = 1'b0; upd = 1'b0; out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (st_r)
      ST_IDLE: if (in_valid) begin
        load = 1'b1; st_nxt = ST_RUN; phase_nxt = 1'b0;
        it_nxt = '0; hq_nxt = '0; hr_nxt = '0;
      end
      ST_RUN: begin
        // Phase 0 registers the products of z, phase 1 checks and updates z.
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (esc_now) st_nxt = ST_COLOR;
          else if (it_r == IW'(MAX_ITER)) st_nxt = ST_COLOR;
          else begin
            upd = 1'b1; it_nxt = it_r + IW'(1);
            if (hsum >= (IW+1)'(MAX_ITER)) begin
              hr_nxt = IW'(hsum - (IW+1)'(MAX_ITER));
              hq_nxt = hq_r + 8'(HueQ + 1);
            end else begin
              hr_nxt = hsum[IW-1:0];
              hq_nxt = hq_r + 8'(HueQ);
            end
          end
        end
      end
      ST_COLOR: st_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r || !out_stall) begin
        out_valid_nxt = 1'b1; st_nxt = ST_IDLE; end
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic esc_hit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; out_valid_r <= 1'b0; esc_hit_r <= 1'b0;
      it_r <= '0; phase_r <= 1'b0; hq_r <= '0; hr_r <= '0;
    end else begin
      st_r <= st_nxt; out_valid_r <= out_valid_nxt; it_r <= it_nxt;
      phase_r <= phase_nxt; hq_r <= hq_nxt; hr_r <= hr_nxt;
      if (st_r == ST_IDLE) esc_hit_r <= 1'b0;
      else if (st_r == ST_RUN && phase_r && esc_now) esc_hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_COLOR) hue_r <= hq_r;
    if (st_r == ST_OUT && st_nxt == ST_IDLE) begin
      {red_r, green_r, blue_r} <= esc_hit_r ? hsv_rgb(hue_r) : 24'd0;
      itc_r <= 8'(it_r);
    end
  end
  assign out_valid = out_valid_r;
  assign out_red = red_r;
  assign out_green = green_r;
  assign out_blue = blue_r;
  assign out_iter_count = itc_r;
endmodule
`default_nettype wire

// ----- rtl/core/jets_check.sv -----
`default_nettype none
module jets_check (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] out_iter_count,
  input wire logic [7:0] out_red,
  input wire logic pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_iter_count) && $stable(out_red))
    else $error("stalled result changed");
  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("accepted twice");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule
bind julia_escape_time_pixel jets_check u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_iter_count(out_iter_count),
  .out_red(out_red), .pready(pready));
`default_nettype wire

// ----- dv/julia_pixel_checker.sv -----
`timescale 1ns / 100ps
module julia_pixel_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic [9:0] in_row,
  input wire logic [9:0] in_col,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [7:0] out_iter_count,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [3:0] paddr,
  input wire logic [31:0] pwdata,
  input wire logic pready,
  output int fail_count,
  output int pending_count,
  output int pixel_count,
  output int escaped_count
);
  import jets_pkg::*;

  localparam int MaxIter = 150;
  localparam int Frac = 28;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] iters;
  } pixel_t;

  logic signed [31:0] c_re, c_im, step_row, step_col;
  pixel_t color_q[$];

  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
    if (v > 96'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -96'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic is_out(input logic signed [31:0] zr, input logic signed [31:0] zi);
    logic [65:0] n;
    n = 66'(zr) * 66'(zr) + 66'(zi) * 66'(zi);
    return n >= (66'd4 << (2 * Frac));
  endfunction

  function automatic logic [7:0] hi8(input int a, input int b);
    return 8'((a * b) >> 8);
  endfunction

  function automatic pixel_t shade_pixel(input logic [9:0] row, input logic [9:0] col);
    logic signed [95:0] wr, wi;
    logic signed [31:0] zr, zi;
    int it, hue, sec, f;
    logic [7:0] p, q, t, v;
    logic done;
    pixel_t px;
    zr = clamp32($signed({86'd0, col}) * 96'(step_col) - (96'sd1 <<< Frac));
    zi = clamp32($signed({86'd0, row}) * 96'(step_row) - (96'sd1 <<< Frac));
    it = 0;
    done = is_out(zr, zi);
    while (it < MaxIter && !done) begin
      wr = (96'(zr) * 96'(zr) - 96'(zi) * 96'(zi)) >>> Frac;
      wi = (96'(zr) * 96'(zi)) >>> (Frac - 1);
      zr = clamp32(wr + 96'(c_re));
      zi = clamp32(wi + 96'(c_im));
      done = is_out(zr, zi);
      it++;
    end
    px = '0;
    px.iters = 8'(it);
    if (done) begin
      hue = ((it * 360) / MaxIter) % 256;
      v = 8'd150;
      sec = hue / 43;
      f = ((hue - sec * 43) * 6) & 255;
      p = hi8(150, 255 - 150);
      q = hi8(150, 255 - ((150 * f) >> 8));
      t = hi8(150, 255 - ((150 * (255 - f)) >> 8));
      case (sec)
        0: begin px.red = v; px.green = t; px.blue = p; end
        1: begin px.red = q; px.green = v; px.blue = p; end
        2: begin px.red = p; px.green = v; px.blue = t; end
        3: begin px.red = p; px.green = q; px.blue = v; end
        4: begin px.red = t; px.green = p; px.blue = v; end
        default: begin px.red = v; px.green = p; px.blue = q; end
      endcase
    end
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      c_re <= CReRst;
      c_im <= CImRst;
      step_row <= RowStepRst;
      step_col <= ColStepRst;
      fail_count <= 0;
      pending_count <= 0;
      pixel_count <= 0;
      escaped_count <= 0;
      color_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_C_REAL: c_re <= pwdata;
          REG_C_IMAG: c_im <= pwdata;
          REG_ROW_STEP: step_row <= pwdata;
          REG_COL_STEP: step_col <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) color_q.push_back(shade_pixel(in_row, in_col));
      if (out_valid && !out_stall) begin
        pixel_count <= pixel_count + 1;
        if (color_q.size() == 0) begin
          $error("Result transfer with no pixel outstanding.");
          errs++;
        end else begin
          want = color_q.pop_front();
          if (want.iters != MaxIter || want.red != 0) escaped_count <= escaped_count + 1;
          if (out_red != want.red) begin
            $error("red: expected %0d, actual %0d", want.red, out_red);
            errs++;
          end
          if (out_green != want.green) begin
            $error("green: expected %0d, actual %0d", want.green, out_green);
            errs++;
          end
          if (out_blue != want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, out_blue);
            errs++;
          end
          if (out_iter_count != want.iters) begin
            $error("iter_count: expected %0d, actual %0d", want.iters, out_iter_count);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= color_q.size();
    end
  end
endmodule

// ----- dv/julia_escape_time_pixel_test.sv -----
`timescale 1ns / 100ps
module julia_escape_time_pixel_test;
  import jets_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [9:0] in_row = '0;
  logic [9:0] in_col = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire logic in_stall, out_valid, pready;
  wire logic [7:0] out_red, out_green, out_blue, out_iter_count;
  wire logic [31:0] prdata;
  int fail_count, pending_count, pixel_count, escaped_count;
  int idle_count = 0;
  logic sink_hold = 1'b0;
  logic sink_calm = 1'b0;

  always #5 clk = ~clk;

  julia_escape_time_pixel u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_row, .in_col,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_iter_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  julia_pixel_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_row, .in_col,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_iter_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_count, .pixel_count, .escaped_count
  );

  always @(posedge clk) begin
    if (sink_hold) out_stall <= 1'b1;
    else if (sink_calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_view(input logic [31:0] cre, input logic [31:0] cim,
                           input logic [31:0] rstep, input logic [31:0] cstep);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_C_REAL, cre);
    write_reg(REG_C_IMAG, cim);
    write_reg(REG_ROW_STEP, rstep);
    write_reg(REG_COL_STEP, cstep);
  endtask

  task automatic send_pixel(input logic [9:0] row, input logic [9:0] col, input logic gaps);
    @(posedge clk);
    while (gaps && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row <= row;
    in_col <= col;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
  endtask

  task automatic random_pixels(input int n, input logic gaps);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_pixel(10'($urandom), 10'($urandom), gaps);
      else send_pixel(10'($urandom_range(99)), 10'($urandom_range(149)), gaps);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_pixel(10'd0, 10'd0, 1'b0);
    send_pixel(10'd1023, 10'd1023, 1'b0);
    send_pixel(10'd50, 10'd75, 1'b0);
    send_pixel(10'd75, 10'd100, 1'b0);
    send_pixel(10'd0, 10'd1023, 1'b0);
    send_pixel(10'd1023, 10'd0, 1'b0);
    send_pixel(10'd512, 10'd341, 1'b0);
    send_pixel(10'd682, 10'd682, 1'b0);
    load_view(32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(10'd0, 10'd0, 1'b0);
    send_pixel(10'd1023, 10'd1023, 1'b0);
    load_view(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_pixel(10'd1, 10'd1, 1'b0);
    send_pixel(10'd1023, 10'd1023, 1'b0);
    send_pixel(10'd0, 10'd0, 1'b0);
    load_view(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_pixel(10'd1023, 10'd1023, 1'b0);
    send_pixel(10'd1, 10'd0, 1'b0);
    load_view(32'hF3333333, 32'h02B851EC, 32'd894785, 32'd671089);
    send_pixel(10'd299, 10'd200, 1'b0);
    send_pixel(10'd150, 10'd200, 1'b0);
    random_pixels(400, 1'b1);
    sink_hold <= 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        sink_hold <= 1'b0;
      end
      random_pixels(10, 1'b0);
    join
    load_view(32'd76502958, 32'd2684355, 32'd894785, 32'd671089);
    sink_calm <= 1'b1;
    random_pixels(300, 1'b0);
    sink_calm <= 1'b0;
    random_pixels(300, 1'b1);
    load_view($urandom, $urandom, $urandom, $urandom);
    random_pixels(300, 1'b1);
    load_view(32'hFB333333 ^ ($urandom & 32'h00FFFFFF), $urandom & 32'h0FFFFFFF,
              32'd1048576, 32'd1048576);
    random_pixels(400, 1'b1);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d pixels (%0d colored) over seven register settings, with stalls.",
             pixel_count, escaped_count);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/jets_pkg.sv
rtl/core/jets_cell.sv
rtl/core/julia_escape_time_pixel.sv
rtl/core/jets_check.sv
dv/julia_pixel_checker.sv
dv/julia_escape_time_pixel_test.sv
